// File: design/qoi_pkg.sv
// Shared types, chunk tags and the table hash for the QOI pixel encoder.
// No dependencies; the encoder top, qoi_enc and qoi_obuf refer to this package by scope.
package qoi_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned HASH_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned MAX_BYTES   = 6;
  localparam int unsigned CHUNK_BYTES = 5;

  localparam logic [5:0] RUN_MAX = 6'd62;

  localparam logic [7:0] TAG_INDEX = 8'h00;
  localparam logic [7:0] TAG_DIFF  = 8'h40;
  localparam logic [7:0] TAG_LUMA  = 8'h80;
  localparam logic [7:0] TAG_RUN   = 8'hc0;
  localparam logic [7:0] TAG_RGB   = 8'hfe;
  localparam logic [7:0] TAG_RGBA  = 8'hff;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  localparam pixel_t PRIOR_RESET = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hff};

  // Bytes produced by one pixel; element 0 leaves first.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      dup;
    logic [5:0]                run_next;
  } step_t;

  // (r*3 + g*5 + b*7 + a*11) mod 64, worked in six bits.
  function automatic logic [HASH_W-1:0] pixel_hash(input pixel_t px);
    logic [HASH_W-1:0] r6, g6, b6, a6;
    r6 = px.r[HASH_W-1:0];
    g6 = px.g[HASH_W-1:0];
    b6 = px.b[HASH_W-1:0];
    a6 = px.a[HASH_W-1:0];
    return r6 * HASH_W'(3) + g6 * HASH_W'(5) + b6 * HASH_W'(7) + a6 * HASH_W'(11);
  endfunction

endpackage

// File: design/qoi_pixel_if.sv
// Pixel channel: valid/ready handshake with one RGBA pixel and an end flag.
// Depends on nothing.
interface qoi_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       final_pixel;

  modport source (output valid, red, green, blue, alpha, final_pixel, input ready);
  modport sink   (input valid, red, green, blue, alpha, final_pixel, output ready);
endinterface

// File: design/qoi_byte_if.sv
// Byte channel: valid/ready handshake carrying one chunk byte and two markers.
// Depends on nothing.
interface qoi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       item_last;
  logic       image_last;

  modport source (output valid, out_byte, item_last, image_last, input ready);
  modport sink   (input valid, out_byte, item_last, image_last, output ready);
endinterface

// File: design/qoi_pixel_encoder.sv
// QOI chunk encoder top level: input register, seen-pixel table, state, output buffer.
// Uses qoi_pkg, qoi_pixel_if, qoi_byte_if, qoi_ram, qoi_enc and qoi_obuf.
//
// Usage:
//   pixel : one RGBA pixel per transfer; final_pixel marks the last pixel of an image.
//   chunk : the QOI chunk stream, one byte per transfer, header and footer excluded.
//           item_last marks the last byte a pixel causes, image_last the image's final
//           byte. A repeated pixel causes no byte unless it fills a run or is final.
//   Order: a pixel is registered in the input register, then encoded and loaded into
//   the output buffer once that is free; its first byte is offered from the buffer.
//   Throughput: one pixel per cycle while each pixel yields at most one byte and
//   chunk.ready stays high. A pixel with more bytes (up to 6: a run flush plus an RGBA
//   chunk) holds the output buffer until its last byte leaves the single byte port,
//   and the next pixel waits in the input register; run-only pixels pass without waiting.
//   Reset: synchronous, clears the previous pixel, run count and the 64 table valid
//   bits at once; no clearing pass. The same happens after every final pixel.
//   Stall: when chunk.ready is low the buffer holds its byte; a pixel that yields bytes
//   then waits in the input register and pixel.ready drops.
module qoi_pixel_encoder (
  input  logic         clk,
  input  logic         rst,
  qoi_pixel_if.sink    pixel,
  qoi_byte_if.source   chunk
);

  localparam int unsigned HW = qoi_pkg::HASH_W;

  qoi_pkg::pixel_t   in_px;
  logic              in_acc;
  logic [HW-1:0]     in_hash;

  logic              s1_valid;
  qoi_pkg::pixel_t   s1_px;
  logic              s1_fin;
  logic [HW-1:0]     s1_hash;
  logic              s1_adv;

  qoi_pkg::pixel_t   prior;
  logic [5:0]        run;
  logic [qoi_pkg::TABLE_DEPTH-1:0] seen_valid;

  logic              we;
  logic [HW-1:0]     raddr;
  qoi_pkg::pixel_t   rdata;
  logic              byp_hit;
  qoi_pkg::pixel_t   byp_data;
  qoi_pkg::pixel_t   entry;

  qoi_pkg::step_t    step;
  logic              obuf_free;
  logic              obuf_load;

  assign in_px   = '{r: pixel.red, g: pixel.green, b: pixel.blue, a: pixel.alpha};
  assign in_hash = qoi_pkg::pixel_hash(in_px);
  assign in_acc  = pixel.valid && pixel.ready;

  assign s1_adv      = s1_valid && ((step.count == 3'd0) || obuf_free);
  assign pixel.ready = !s1_valid || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px   <= in_px;
      s1_fin  <= pixel.final_pixel;
      s1_hash <= in_hash;
    end
  end

  // table: re-read the held pixel's slot while it waits
  assign raddr = in_acc ? in_hash : s1_hash;
  assign we    = s1_adv && !step.dup && !s1_fin;

  qoi_ram #(
    .WIDTH ($bits(qoi_pkg::pixel_t)),
    .DEPTH (qoi_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (s1_hash),
    .wdata (s1_px),
    .raddr (raddr),
    .rdata (rdata)
  );

  // forward a write that clashed with the read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= we && (s1_hash == raddr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= s1_px;
  end

  always_comb begin
    if (!seen_valid[s1_hash]) begin
      entry = '0;
    end else if (byp_hit) begin
      entry = byp_data;
    end else begin
      entry = rdata;
    end
  end

  qoi_enc u_enc (
    .px    (s1_px),
    .prior (prior),
    .entry (entry),
    .hash  (s1_hash),
    .run   (run),
    .fin   (s1_fin),
    .step  (step)
  );

  // encoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      prior      <= qoi_pkg::PRIOR_RESET;
      run        <= 6'd0;
      seen_valid <= '0;
    end else if (s1_adv) begin
      if (s1_fin) begin
        prior      <= qoi_pkg::PRIOR_RESET;
        run        <= 6'd0;
        seen_valid <= '0;
      end else begin
        run <= step.run_next;
        if (!step.dup) begin
          prior               <= s1_px;
          seen_valid[s1_hash] <= 1'b1;
        end
      end
    end
  end

  assign obuf_load = s1_adv && (step.count != 3'd0);

  qoi_obuf u_obuf (
    .clk   (clk),
    .rst   (rst),
    .load  (obuf_load),
    .bytes (step.bytes),
    .count (step.count),
    .fin   (s1_fin),
    .free  (obuf_free),
    .chunk (chunk)
  );

  // a final pixel leaves the encoder state as after reset
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_fin |=> (run == 6'd0) && (seen_valid == '0) &&
                         (prior == qoi_pkg::PRIOR_RESET))
    else $error("state not cleared after final pixel");

  // the input side only stalls behind a held pixel
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> s1_valid)
    else $error("pixel port stalled with empty input register");

  // a final pixel always yields a byte, and the image end closes a pixel
  a_final_bytes: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_fin |-> (step.count != 3'd0) && obuf_load)
    else $error("final pixel produced no byte");

  a_image_last: assert property (@(posedge clk) disable iff (rst)
    chunk.valid && chunk.image_last |-> chunk.item_last)
    else $error("image_last without item_last");

endmodule

// File: design/qoi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read before write on an address clash. No dependencies.
module qoi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/qoi_enc.sv
// Chunk selection for one pixel: run handling, INDEX/DIFF/LUMA/RGB/RGBA.
// Uses qoi_pkg for tags, pixel_t and step_t.
module qoi_enc (
  input  qoi_pkg::pixel_t                 px,
  input  qoi_pkg::pixel_t                 prior,
  input  qoi_pkg::pixel_t                 entry,
  input  logic [qoi_pkg::HASH_W-1:0]      hash,
  input  logic [5:0]                      run,
  input  logic                            fin,
  output qoi_pkg::step_t                  step
);

  logic [7:0] ur, ug, ub, urg, ubg;
  logic [7:0] dr2, dg2, db2, dg32, drg8, dbg8;
  logic       diff_ok, luma_ok;
  logic [5:0] run_inc;
  logic [7:0] flush_byte;
  logic [qoi_pkg::CHUNK_BYTES-1:0][7:0] cbytes;
  logic [2:0] clen;

  always_comb begin
    ur   = px.r - prior.r;
    ug   = px.g - prior.g;
    ub   = px.b - prior.b;
    urg  = ur - ug;
    ubg  = ub - ug;
    // bias so that each signed range becomes a plain unsigned bound
    dr2  = ur + 8'd2;
    dg2  = ug + 8'd2;
    db2  = ub + 8'd2;
    dg32 = ug + 8'd32;
    drg8 = urg + 8'd8;
    dbg8 = ubg + 8'd8;
    diff_ok = (dr2 < 8'd4) && (dg2 < 8'd4) && (db2 < 8'd4);
    luma_ok = (dg32 < 8'd64) && (drg8 < 8'd16) && (dbg8 < 8'd16);
  end

  always_comb begin
    cbytes = '0;
    clen   = 3'd1;
    if (entry == px) begin
      cbytes[0] = qoi_pkg::TAG_INDEX | {2'b00, hash};
    end else if (px.a == prior.a) begin
      if (diff_ok) begin
        cbytes[0] = qoi_pkg::TAG_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
      end else if (luma_ok) begin
        cbytes[0] = qoi_pkg::TAG_LUMA | {2'b00, dg32[5:0]};
        cbytes[1] = {drg8[3:0], dbg8[3:0]};
        clen      = 3'd2;
      end else begin
        cbytes[0] = qoi_pkg::TAG_RGB;
        cbytes[1] = px.r;
        cbytes[2] = px.g;
        cbytes[3] = px.b;
        clen      = 3'd4;
      end
    end else begin
      cbytes[0] = qoi_pkg::TAG_RGBA;
      cbytes[1] = px.r;
      cbytes[2] = px.g;
      cbytes[3] = px.b;
      cbytes[4] = px.a;
      clen      = 3'd5;
    end
  end

  always_comb begin
    run_inc    = run + 6'd1;
    flush_byte = qoi_pkg::TAG_RUN | {2'b00, run - 6'd1};
    step.dup   = (px == prior);
    if (step.dup) begin
      // grown run is run_inc, so its stored length field is the old count
      step.bytes    = {{(qoi_pkg::MAX_BYTES-1){8'h00}}, qoi_pkg::TAG_RUN | {2'b00, run}};
      step.count    = ((run_inc == qoi_pkg::RUN_MAX) || fin) ? 3'd1 : 3'd0;
      step.run_next = (run_inc == qoi_pkg::RUN_MAX) ? 6'd0 : run_inc;
    end else if (run != 6'd0) begin
      step.bytes    = {cbytes, flush_byte};
      step.count    = clen + 3'd1;
      step.run_next = 6'd0;
    end else begin
      step.bytes    = {8'h00, cbytes};
      step.count    = clen;
      step.run_next = 6'd0;
    end
  end

endmodule

// File: design/qoi_obuf.sv
// Output buffer: holds the bytes of one pixel and shifts them out one per transfer.
// Uses qoi_pkg and the qoi_byte_if interface.
module qoi_obuf (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic [qoi_pkg::MAX_BYTES-1:0][7:0]    bytes,
  input  logic [2:0]                            count,
  input  logic                                  fin,
  output logic                                  free,
  qoi_byte_if.source                            chunk
);

  logic [qoi_pkg::MAX_BYTES-1:0][7:0] buffer;
  logic [2:0]                         rem;
  logic                               fin_held;
  logic                               xfer;

  assign chunk.valid      = (rem != 3'd0);
  assign chunk.out_byte   = buffer[0];
  assign chunk.item_last  = (rem == 3'd1);
  assign chunk.image_last = (rem == 3'd1) && fin_held;

  assign xfer = chunk.valid && chunk.ready;
  // free when empty or when the last byte leaves in this cycle
  assign free = (rem == 3'd0) || ((rem == 3'd1) && chunk.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
    end else if (load) begin
      rem <= count;
    end else if (xfer) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buffer   <= bytes;
      fin_held <= fin;
    end else if (xfer) begin
      buffer <= {8'h00, buffer[qoi_pkg::MAX_BYTES-1:1]};
    end
  end

endmodule
